// File: design/guided_chunk_row_dispenser_assert.svh
`ifndef GUIDED_CHUNK_ROW_DISPENSER_ASSERT_SVH
`define GUIDED_CHUNK_ROW_DISPENSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk and quiet during reset.
`define GCRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcrd: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge of clk and quiet during reset.
`define GCRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcrd: next-cycle check failed");

`endif

// File: design/gcrd_pkg.sv
package gcrd_pkg;

  // Default sizing of the task list and the joined row space.
  localparam int DEF_MAX_TASKS = 64;
  localparam int DEF_ROW_BITS  = 24;

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int DIV_W   = 8;
  localparam int CHUNK_W = 9;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;
  localparam int REG_W   = 2;

  // Opcodes of an input item.
  localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_CLAIM  = 2'd2;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [REG_W-1:0] REG_DIVISOR   = 2'd0;
  localparam logic [REG_W-1:0] REG_CHUNK_MIN = 2'd1;
  localparam logic [REG_W-1:0] REG_CHUNK_MAX = 2'd2;

  // Register reset values.
  localparam logic [DIV_W-1:0]   DIVISOR_RST   = 8'd2;
  localparam logic [CHUNK_W-1:0] CHUNK_MIN_RST = 9'd16;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX_RST = 9'd256;

endpackage

// File: design/gcrd_div.sv
module gcrd_div
  import gcrd_pkg::*;
#(
  parameter int ROW_BITS = DEF_ROW_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ROW_BITS-1:0] dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic                done,
  output logic [ROW_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(ROW_BITS + 1);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ROW_BITS-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    dvs;
  logic [DIV_W:0]      shifted;
  logic [DIV_W:0]      diff;
  logic                fits;

  // A zero divisor divides as one.
  assign dvs     = (divisor == '0) ? DIV_W'(1) : divisor;
  assign shifted = {rem_r, quo_r[ROW_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of quo_r while quotient bits shift in at the bottom.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(ROW_BITS);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[ROW_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/guided_chunk_row_dispenser.sv
// Begin and append transfers are taken while idle, and busy stays low for them.
// A claim holds busy through the divide, clamp, load and evaluation states, walking at least one task,
// and the next command is taken once the walk has reached the end of the claim.
// The first segment is strobed after the bit-serial divider, the clamp and the memory load,
// then up to one segment a cycle as the walk goes on; an exhausted claim answers next cycle.
// rst_n is synchronous, active low; results are strobed and cannot be stalled.
module guided_chunk_row_dispenser
  import gcrd_pkg::*;
#(
  parameter int  MAX_TASKS = DEF_MAX_TASKS,
  parameter int  ROW_BITS  = DEF_ROW_BITS,
  localparam int TIDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [ROW_BITS-1:0] in_task_rows,
  // Result channel.
  output logic                out_valid,
  output logic [TIDX_W-1:0]   out_task_index,
  output logic [ROW_BITS-1:0] out_local_row,
  output logic [ROW_BITS-1:0] out_global_row,
  output logic [CHUNK_W-1:0]  out_row_count,
  output logic                out_exhausted,
  output logic                out_last,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (ROW_BITS > CHUNK_W) ? ROW_BITS : CHUNK_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;

  // Running total of rows and the claim pointer of the current job.
  logic [ROW_BITS-1:0] total_r, total_nxt;
  logic [ROW_BITS-1:0] next_row_r, next_row_nxt;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write completes when psel, penable and pwrite
  // are high; pready is tied high, so every access finishes in its access
  // cycle. Only the word index in paddr[3:2] is decoded.
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]   divisor_r, divisor_nxt;
  logic [CHUNK_W-1:0] chunk_min_r, chunk_min_nxt;
  logic [CHUNK_W-1:0] chunk_max_r, chunk_max_nxt;
  logic               cfg_wr;
  logic [REG_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_AW-1:APB_AW-REG_W];

  always_comb begin
    divisor_nxt   = divisor_r;
    chunk_min_nxt = chunk_min_r;
    chunk_max_nxt = chunk_max_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DIVISOR:   divisor_nxt   = pwdata[DIV_W-1:0];
        REG_CHUNK_MIN: chunk_min_nxt = pwdata[CHUNK_W-1:0];
        REG_CHUNK_MAX: chunk_max_nxt = pwdata[CHUNK_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DIVISOR:   prdata = APB_DW'(divisor_r);
      REG_CHUNK_MIN: prdata = APB_DW'(chunk_min_r);
      REG_CHUNK_MAX: prdata = APB_DW'(chunk_max_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r   <= DIVISOR_RST;
      chunk_min_r <= CHUNK_MIN_RST;
      chunk_max_r <= CHUNK_MAX_RST;
    end else begin
      divisor_r   <= divisor_nxt;
      chunk_min_r <= chunk_min_nxt;
      chunk_max_r <= chunk_max_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Task start memory. Each appended task records its first global row here.
  // Entries are only read below the task count, so the array needs no reset.
  // Reads are registered: data for an address shows up in the following cycle.
  // ---------------------------------------------------------------------------
  logic [ROW_BITS-1:0] task_start_mem [MAX_TASKS];
  logic                mem_we;
  logic [TIDX_W-1:0]   mem_waddr;
  logic [TIDX_W-1:0]   mem_raddr;
  logic [ROW_BITS-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      task_start_mem[mem_waddr] <= total_r;
    end
    mem_rdata_r <= task_start_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Divider: remaining rows over the divisor, one bit per cycle.
  // ---------------------------------------------------------------------------
  logic                div_start;
  logic                div_done;
  logic [ROW_BITS-1:0] div_quo;
  logic [ROW_BITS-1:0] rem_rows;

  assign rem_rows = total_r - next_row_r;

  gcrd_div #(
    .ROW_BITS (ROW_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_rows),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Job state and claim sequencer.
  //
  // cursor_r remembers the task that held the end of the previous claim. Tasks
  // before it end at or below next_row_r, so a claim walk starts there rather
  // than at task zero. Tasks appended later start at or above the old total,
  // which keeps that true.
  //
  // The walk reads task t+1 ahead so that the end of task t (the start of the
  // following task, or the total for the final task) is at hand each cycle.
  // ---------------------------------------------------------------------------
  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    task_count_r, task_count_nxt;
  logic [TIDX_W-1:0]   cursor_r, cursor_nxt;
  logic [TIDX_W-1:0]   t_r, t_nxt;
  logic [ROW_BITS-1:0] s_r, s_nxt;
  logic [ROW_BITS-1:0] g0_r, g0_nxt;
  logic [ROW_BITS-1:0] g1_r, g1_nxt;

  logic                accept;
  logic [ROW_BITS:0]   app_sum;
  logic                app_room;
  logic [CNT_W-1:0]    t_plus1;
  logic                has_next_task;

  logic [CMP_W-1:0]    q_ext, cmin_ext, cmax_ext, rem_ext, c_ext;
  logic [CHUNK_W-1:0]  chunk;
  logic [ROW_BITS:0]   g_sum;
  logic [ROW_BITS-1:0] g1_calc;

  logic [ROW_BITS-1:0] seg_end, seg_lo, seg_hi;
  logic [ROW_BITS-1:0] seg_len;

  logic                emit;
  logic [TIDX_W-1:0]   em_index;
  logic [ROW_BITS-1:0] em_local, em_global;
  logic [CHUNK_W-1:0]  em_count;
  logic                em_exh, em_last;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign app_sum  = {1'b0, total_r} + {1'b0, in_task_rows};
  assign app_room = (task_count_r < CNT_W'(MAX_TASKS));
  assign mem_waddr = task_count_r[TIDX_W-1:0];

  // The end of task t comes from the memory unless t is the final task.
  assign t_plus1       = CNT_W'(t_r) + CNT_W'(1);
  assign has_next_task = (t_plus1 < task_count_r);
  assign seg_end       = has_next_task ? mem_rdata_r : total_r;
  assign seg_lo        = (s_r > g0_r) ? s_r : g0_r;
  assign seg_hi        = (seg_end < g1_r) ? seg_end : g1_r;
  assign seg_len       = seg_hi - seg_lo;

  // Clamp: the minimum is tested first, so when it lies above the maximum it wins
  // for quotients below it; a zero result is raised to one. The chunk always fits 9 bits.
  assign q_ext    = CMP_W'(div_quo);
  assign cmin_ext = CMP_W'(chunk_min_r);
  assign cmax_ext = CMP_W'(chunk_max_r);
  assign rem_ext  = CMP_W'(rem_rows);

  always_comb begin
    if (q_ext < cmin_ext) begin
      c_ext = cmin_ext;
    end else if (q_ext > cmax_ext) begin
      c_ext = cmax_ext;
    end else begin
      c_ext = q_ext;
    end
    if (c_ext == '0) begin
      c_ext = CMP_W'(1);
    end
  end

  // The pointer stops at the total when the chunk covers all that is left.
  assign chunk   = c_ext[CHUNK_W-1:0];
  assign g_sum   = {1'b0, next_row_r} + (ROW_BITS+1)'(chunk);
  assign g1_calc = (c_ext < rem_ext) ? g_sum[ROW_BITS-1:0] : total_r;

  always_comb begin
    state_nxt      = state_r;
    task_count_nxt = task_count_r;
    total_nxt      = total_r;
    next_row_nxt   = next_row_r;
    cursor_nxt     = cursor_r;
    t_nxt          = t_r;
    s_nxt          = s_r;
    g0_nxt         = g0_r;
    g1_nxt         = g1_r;
    mem_we         = 1'b0;
    mem_raddr      = t_r;
    div_start      = 1'b0;
    emit           = 1'b0;
    em_index       = t_r;
    em_local       = seg_lo - s_r;
    em_global      = seg_lo;
    em_count       = seg_len[CHUNK_W-1:0];
    em_exh         = 1'b0;
    em_last        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_BEGIN: begin
              task_count_nxt = '0;
              total_nxt      = '0;
              next_row_nxt   = '0;
              cursor_nxt     = '0;
            end
            OP_APPEND: begin
              // A full list or a total that would overflow ignores the task.
              if (app_room && !app_sum[ROW_BITS]) begin
                mem_we         = 1'b1;
                task_count_nxt = task_count_r + CNT_W'(1);
                total_nxt      = app_sum[ROW_BITS-1:0];
              end
            end
            OP_CLAIM: begin
              if (next_row_r >= total_r) begin
                // Nothing left: one result marked exhausted and last.
                emit      = 1'b1;
                em_index  = '0;
                em_local  = '0;
                em_global = total_r;
                em_count  = '0;
                em_exh    = 1'b1;
                em_last   = 1'b1;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        g0_nxt       = next_row_r;
        g1_nxt       = g1_calc;
        next_row_nxt = g1_calc;
        t_nxt        = cursor_r;
        mem_raddr    = cursor_r;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        s_nxt     = mem_rdata_r;
        mem_raddr = t_plus1[TIDX_W-1:0];
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // Prefetch the start of the task after the next one.
        mem_raddr = t_r + TIDX_W'(2);
        emit      = (seg_lo < seg_hi);
        em_last   = (seg_end >= g1_r);
        if (seg_end >= g1_r) begin
          cursor_nxt = t_r;
          state_nxt  = ST_IDLE;
        end else begin
          s_nxt = seg_end;
          t_nxt = t_plus1[TIDX_W-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= '0;
      total_r      <= '0;
      next_row_r   <= '0;
      cursor_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      total_r      <= total_nxt;
      next_row_r   <= next_row_nxt;
      cursor_r     <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    s_r  <= s_nxt;
    g0_r <= g0_nxt;
    g1_r <= g1_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register. Each segment is one transfer, shown for exactly one
  // cycle; the strobe clears on reset, the payload does not need to.
  // ---------------------------------------------------------------------------
  logic                out_valid_r;
  logic [TIDX_W-1:0]   out_task_index_r;
  logic [ROW_BITS-1:0] out_local_row_r;
  logic [ROW_BITS-1:0] out_global_row_r;
  logic [CHUNK_W-1:0]  out_row_count_r;
  logic                out_exhausted_r;
  logic                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_task_index_r <= em_index;
      out_local_row_r  <= em_local;
      out_global_row_r <= em_global;
      out_row_count_r  <= em_count;
      out_exhausted_r  <= em_exh;
      out_last_r       <= em_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_task_index = out_task_index_r;
  assign out_local_row  = out_local_row_r;
  assign out_global_row = out_global_row_r;
  assign out_row_count  = out_row_count_r;
  assign out_exhausted  = out_exhausted_r;
  assign out_last       = out_last_r;

endmodule

// File: design/gcrd_checker.sv
`include "guided_chunk_row_dispenser_assert.svh"

module gcrd_port_checker
  import gcrd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [OP_W-1:0]    in_opcode,
  input logic               out_valid,
  input logic [CHUNK_W-1:0] out_row_count,
  input logic               out_exhausted,
  input logic               out_last
);

  // An exhausted transfer is a lone, empty result.
  `GCRD_ASSERT_NOW(a_exh_empty, out_valid && out_exhausted, out_row_count == '0 && out_last)

  // A regular segment always carries rows.
  `GCRD_ASSERT_NOW(a_seg_rows, out_valid && !out_exhausted, out_row_count != '0)

  // An accepted claim either answers at once or keeps the block busy.
  `GCRD_ASSERT_NEXT(a_claim_act, start && !busy && in_opcode == OP_CLAIM, busy || out_valid)

  // Once the final segment of a claim is out, the block takes commands again.
  `GCRD_ASSERT_NOW(a_last_idle, out_valid && out_last, !busy)

endmodule

bind guided_chunk_row_dispenser gcrd_port_checker u_gcrd_checker (.*);
